// ----- rtl/bdrc_pkg.sv -----
// Shared types, constants and commutation tables of the duty ramp and commutation core.
`timescale 1ns / 1ps
package bdrc_pkg;

  localparam int NUM_AXES   = 2;
  localparam int DUTY_W     = 15;
  localparam int WIN_W      = 8;
  localparam int HALL_W     = 3;
  localparam int COMM_W     = 4;
  localparam int MASK_W     = 6;
  localparam int ACC_W      = 10;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 2;

  localparam logic [ACC_W-1:0]  ACC_MAX        = 10'd1023;
  localparam logic [WIN_W-1:0]  WINDOW_RESET   = 8'd20;
  localparam logic [DUTY_W-1:0] DUTY_FLOOR_RST = 15'd0;
  localparam logic [DUTY_W-1:0] STEP_RST       = 15'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUTY_FLOOR = 2'd0,
    REG_STEP       = 2'd1,
    REG_WINDOW     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_floor;
    logic [DUTY_W-1:0] step;
  } lane_cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] req_duty;
    logic              req_dir;
    logic [HALL_W-1:0] hall;
    logic [COMM_W-1:0] comm;
  } lane_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              dir;
    logic [MASK_W-1:0] phase;
    logic [MASK_W-1:0] outm;
    logic [ACC_W-1:0]  speed;
  } lane_res_t;

  typedef lane_res_t [NUM_AXES-1:0] res_t;

  typedef struct packed {
    logic [MASK_W-1:0] phase;
    logic [MASK_W-1:0] outm;
  } comm_entry_t;

  function automatic comm_entry_t comm_lookup(input logic dir, input logic [HALL_W-1:0] hall);
    comm_entry_t e;
    e = '{phase: 6'h3F, outm: 6'h00};
    if (!dir) begin
      case (hall)
        3'd1:    e = '{phase: 6'h0F, outm: 6'h02};
        3'd2:    e = '{phase: 6'h33, outm: 6'h20};
        3'd3:    e = '{phase: 6'h33, outm: 6'h02};
        3'd4:    e = '{phase: 6'h3C, outm: 6'h08};
        3'd5:    e = '{phase: 6'h0F, outm: 6'h08};
        3'd6:    e = '{phase: 6'h3C, outm: 6'h20};
        default: e = '{phase: 6'h3F, outm: 6'h00};
      endcase
    end else begin
      case (hall)
        3'd1:    e = '{phase: 6'h3C, outm: 6'h20};
        3'd2:    e = '{phase: 6'h0F, outm: 6'h08};
        3'd3:    e = '{phase: 6'h3C, outm: 6'h08};
        3'd4:    e = '{phase: 6'h33, outm: 6'h02};
        3'd5:    e = '{phase: 6'h33, outm: 6'h20};
        3'd6:    e = '{phase: 6'h0F, outm: 6'h02};
        default: e = '{phase: 6'h3F, outm: 6'h00};
      endcase
    end
    return e;
  endfunction

endpackage

// ----- rtl/bdrc_if.sv -----
// Valid/ready channel interfaces for tick items and result items.
`timescale 1ns / 1ps
interface bdrc_in_if;
  logic        valid;
  logic        ready;
  logic [14:0] req_duty_a;
  logic        req_dir_a;
  logic [14:0] req_duty_b;
  logic        req_dir_b;
  logic [2:0]  hall_a;
  logic [2:0]  hall_b;
  logic [3:0]  commutations_a;
  logic [3:0]  commutations_b;

  modport source (
    output valid, req_duty_a, req_dir_a, req_duty_b, req_dir_b,
           hall_a, hall_b, commutations_a, commutations_b,
    input  ready
  );
  modport sink (
    input  valid, req_duty_a, req_dir_a, req_duty_b, req_dir_b,
           hall_a, hall_b, commutations_a, commutations_b,
    output ready
  );
endinterface

interface bdrc_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] duty_a;
  logic        dir_a;
  logic [14:0] duty_b;
  logic        dir_b;
  logic [5:0]  phase_mask_a;
  logic [5:0]  out_mask_a;
  logic [5:0]  phase_mask_b;
  logic [5:0]  out_mask_b;
  logic [9:0]  speed_a;
  logic [9:0]  speed_b;

  modport source (
    output valid, duty_a, dir_a, duty_b, dir_b, phase_mask_a, out_mask_a,
           phase_mask_b, out_mask_b, speed_a, speed_b,
    input  ready
  );
  modport sink (
    input  valid, duty_a, dir_a, duty_b, dir_b, phase_mask_a, out_mask_a,
           phase_mask_b, out_mask_b, speed_a, speed_b,
    output ready
  );
endinterface

// ----- rtl/bldc_duty_ramp_reversal_commutation_core.sv -----
// Top level: two axis lanes, shared tick window counter, config registers, result queue.
//
//   channel | direction | handshake          | content
//   in_item | sink      | valid/ready        | requested duty/dir, hall, commutations per axis
//   out_res | source    | valid/ready        | duty, dir, phase/out masks, speed per axis
//   cfg_*   | write     | cfg_we             | duty floor, step, window_ticks by index
//
// One tick item per cycle while the queue has room; each lane finishes its item in the cycle
// it is accepted and the merged result is registered into a two-entry queue.
// Input stalls only when both queue entries hold results not yet taken.
// Synchronous reset clears lane state, the tick counter and the queue, and loads the
// config register defaults.
`timescale 1ns / 1ps
module bldc_duty_ramp_reversal_commutation_core
  import bdrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  bdrc_in_if.sink               in_item,
  bdrc_out_if.source            out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DUTY_W-1:0] duty_floor_r;
  logic [DUTY_W-1:0] step_r;
  logic [WIN_W-1:0]  window_r;
  logic [WIN_W-1:0]  tick_r, tick_nxt;
  logic              fire, latch, can_push;
  lane_cfg_t         lane_cfg;
  lane_in_t          lane_in [NUM_AXES];
  res_t              lane_res, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_floor_r <= DUTY_FLOOR_RST;
      step_r       <= STEP_RST;
      window_r     <= WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DUTY_FLOOR: duty_floor_r <= cfg_data[DUTY_W-1:0];
        REG_STEP:       step_r       <= cfg_data[DUTY_W-1:0];
        REG_WINDOW:     window_r     <= cfg_data[WIN_W-1:0];
        default:        ;
      endcase
    end
  end

  assign fire     = in_item.valid & can_push;
  assign latch    = (tick_r == window_r);
  assign tick_nxt = latch ? '0 : tick_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else if (fire) begin
      tick_r <= tick_nxt;
    end
  end

  assign lane_cfg = '{duty_floor: duty_floor_r, step: step_r};
  assign lane_in[0] = '{req_duty: in_item.req_duty_a, req_dir: in_item.req_dir_a,
                        hall: in_item.hall_a, comm: in_item.commutations_a};
  assign lane_in[1] = '{req_duty: in_item.req_duty_b, req_dir: in_item.req_dir_b,
                        hall: in_item.hall_b, comm: in_item.commutations_b};

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    bdrc_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .fire     (fire),
      .latch    (latch),
      .cfg      (lane_cfg),
      .lane_in  (lane_in[g]),
      .lane_res (lane_res[g])
    );
  end

  bdrc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_res  (lane_res),
    .can_push  (can_push),
    .res_valid (out_res.valid),
    .pop       (out_res.valid & out_res.ready),
    .res_head  (head)
  );

  assign in_item.ready        = can_push;
  assign out_res.duty_a       = head[0].duty;
  assign out_res.dir_a        = head[0].dir;
  assign out_res.phase_mask_a = head[0].phase;
  assign out_res.out_mask_a   = head[0].outm;
  assign out_res.speed_a      = head[0].speed;
  assign out_res.duty_b       = head[1].duty;
  assign out_res.dir_b        = head[1].dir;
  assign out_res.phase_mask_b = head[1].phase;
  assign out_res.out_mask_b   = head[1].outm;
  assign out_res.speed_b      = head[1].speed;

endmodule

// ----- rtl/bdrc_lane.sv -----
// One axis lane: duty slew, direction reversal, commutation lookup and speed window.
`timescale 1ns / 1ps
module bdrc_lane
  import bdrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  logic      latch,
  input  lane_cfg_t cfg,
  input  lane_in_t  lane_in,
  output lane_res_t lane_res
);

  logic [DUTY_W-1:0] duty_r, duty_nxt;
  logic              dir_r, dir_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [ACC_W-1:0]  spd_r, spd_nxt;
  logic [ACC_W:0]    acc_sum;
  logic [ACC_W-1:0]  acc_sat;
  logic [DUTY_W-1:0] diff_up, diff_dn;
  comm_entry_t       entry;

  always_comb begin
    acc_sum = {1'b0, acc_r} + {{(ACC_W + 1 - COMM_W){1'b0}}, lane_in.comm};
    acc_sat = (acc_sum > {1'b0, ACC_MAX}) ? ACC_MAX : acc_sum[ACC_W-1:0];
    if (latch) begin
      spd_nxt = acc_sat;
      acc_nxt = '0;
    end else begin
      spd_nxt = spd_r;
      acc_nxt = acc_sat;
    end
  end

  always_comb begin
    diff_up  = lane_in.req_duty - duty_r;
    diff_dn  = duty_r - lane_in.req_duty;
    duty_nxt = duty_r;
    dir_nxt  = dir_r;
    if (lane_in.req_dir != dir_r) begin
      if (duty_r <= cfg.duty_floor) begin
        dir_nxt = lane_in.req_dir;
      end else begin
        duty_nxt = (duty_r > cfg.step) ? duty_r - cfg.step : '0;
      end
    end else if (lane_in.req_duty > duty_r) begin
      duty_nxt = (diff_up >= cfg.step) ? duty_r + cfg.step : lane_in.req_duty;
    end else if (lane_in.req_duty < duty_r) begin
      duty_nxt = (diff_dn >= cfg.step) ? duty_r - cfg.step : lane_in.req_duty;
    end
  end

  always_comb begin
    entry          = comm_lookup(dir_nxt, lane_in.hall);
    lane_res.duty  = duty_nxt;
    lane_res.dir   = dir_nxt;
    lane_res.phase = entry.phase;
    lane_res.outm  = entry.outm;
    lane_res.speed = spd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r <= DUTY_FLOOR_RST;
      dir_r  <= 1'b0;
      acc_r  <= '0;
      spd_r  <= '0;
    end else if (fire) begin
      duty_r <= duty_nxt;
      dir_r  <= dir_nxt;
      acc_r  <= acc_nxt;
      spd_r  <= spd_nxt;
    end
  end

endmodule

// ----- rtl/bdrc_out_stage.sv -----
// Two-entry result queue that merges the lane results and decouples the output handshake.
`timescale 1ns / 1ps
module bdrc_out_stage
  import bdrc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  output logic can_push,
  output logic res_valid,
  input  logic pop,
  output res_t res_head
);

  res_t       ent_r [2];
  logic       head_r, head_nxt;
  logic [1:0] count_r, count_nxt;
  logic       wr_idx;

  always_comb begin
    can_push  = (count_r != 2'd2);
    res_valid = (count_r != 2'd0);
    res_head  = ent_r[head_r];
    wr_idx    = head_r ^ count_r[0];
    head_nxt  = pop ? ~head_r : head_r;
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 1'b0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_idx] <= push_res;
    end
  end

endmodule
